FILE: design/ad8_pkg.sv
// shared types and constants for the 8-bit arithmetic decoder
package ad8_pkg;

  localparam int DVD_W = 15;
  localparam int DSR_W = 9;
  localparam logic [7:0] HIGH_INIT = 8'd255;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_BYTE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_CHECK,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_ERR,
    ST_SCALE,
    ST_MUL1,
    ST_DIV1,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_MUL2,
    ST_DIV2,
    ST_MUL3,
    ST_DIV3,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol_index;
    logic [6:0] symbol_count;
    logic [7:0] coded_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic       last;
    logic       error;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/ad8_div.sv
// iterative restoring divider, one quotient bit per cycle
module ad8_div (
  input  logic              clk,
  input  logic              rst,
  input  ad8_pkg::div_req_t req,
  output ad8_pkg::div_rsp_t rsp
);

  logic                       busy;
  logic                       done;
  logic [3:0]                 cnt;
  logic [ad8_pkg::DSR_W-1:0]  rem;
  logic [ad8_pkg::DSR_W-1:0]  dsr;
  logic [ad8_pkg::DVD_W-1:0]  quo;
  logic [ad8_pkg::DSR_W:0]    sh;
  logic                       fits;

  assign sh   = {rem, quo[ad8_pkg::DVD_W-1]};
  assign fits = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(ad8_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= ad8_pkg::DSR_W'(sh - {1'b0, dsr});
      end else begin
        rem <= sh[ad8_pkg::DSR_W-1:0];
      end
      quo <= {quo[ad8_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

FILE: design/arithmetic_decoder_8bit.sv
// top level of the 8-bit arithmetic decoder: sequencer, tables and interval state
// Usage: requests arrive on req (req_valid/req_stall), decoded symbols leave on res
// (res_valid/res_stall). A request is taken when valid is high and stall is low.
// Opcode 0 writes one symbol count. Opcode 1 sums the count table (a read and an
// add state per entry), checks the total, then writes the cumulative table (a read
// and a write state per entry); a bad total yields one result with error and last
// set. Opcode 2 hands over a coded byte; the first byte after a start is the tag.
// Each symbol takes one multiply and divide for the search value (no divide when
// the tag is below the low bound), a linear search with a read and a compare state
// per cumulative entry, and two more multiply and divide steps for the new bounds,
// all on the shared divider. Rescaling uses one coded bit per cycle. A symbol is
// shown only once it is known whether another follows, so the last flag is exact.
// Req is stalled while a request is at work. A result waits in the output register
// while res_stall is high; the block holds its sequencer until the register frees.
// Reset clears the count table valid bits at once and returns to idle with an empty
// output register.
module arithmetic_decoder_8bit #(
  parameter int ALPHABET  = 256,
  parameter int MAX_TOTAL = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ad8_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_stall,
  output ad8_pkg::res_t  res
);

  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ALPHABET - 1);

  ad8_pkg::state_t state, state_next;

  logic [AW-1:0] s;
  logic [AW-1:0] k;
  logic [14:0]   acc;
  logic [6:0]    run;
  logic [6:0]    total_count;
  logic [6:0]    symbols_left;
  logic [7:0]    interval_low;
  logic [7:0]    interval_high;
  logic [7:0]    code_tag;
  logic [7:0]    held_byte;
  logic [3:0]    bits_left;
  logic          tag_loaded;
  logic          scale_pending;
  logic [14:0]   prod;
  logic [6:0]    value;
  logic [6:0]    prev;
  logic [6:0]    cum_lo;
  logic [6:0]    cum_hi;
  logic [7:0]    lo_off;
  logic          pend_valid;
  logic          pend_last;
  logic [7:0]    pend_sym;
  logic          div_first;

  logic [6:0]    count_mem [ALPHABET];
  logic          count_valid [ALPHABET];
  logic [6:0]    cum_mem [ALPHABET];
  logic [6:0]    cnt_rd;
  logic          cnt_vld;
  logic [6:0]    cum_rd;
  logic [6:0]    cnt_val;

  ad8_pkg::div_req_t div_req;
  ad8_pkg::div_rsp_t div_rsp;

  logic        accept;
  logic        out_free;
  logic        load_out;
  logic [8:0]  range9;
  logic [8:0]  first9;
  logic        tag_ge;
  logic        same_top;
  logic        mid_band;
  logic        needs_scale;
  logic [2:0]  bit_idx;
  logic        in_bit;
  logic        idx_ok;
  logic        found;

  ad8_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept   = req_valid && !req_stall;
  assign out_free = !res_valid || !res_stall;
  assign range9   = 9'(interval_high - interval_low) + 9'd1;
  assign first9   = 9'(code_tag - interval_low) + 9'd1;
  assign tag_ge   = code_tag >= interval_low;
  assign same_top = interval_low[7] == interval_high[7];
  assign mid_band = (interval_low[7:6] == 2'b01) && (interval_high[7:6] == 2'b10);
  assign needs_scale = same_top || mid_band;
  assign bit_idx  = 3'(ad8_pkg::BYTE_BITS - bits_left);
  assign in_bit   = held_byte[bit_idx];
  assign idx_ok   = {1'b0, req.symbol_index} < 9'(ALPHABET);
  assign cnt_val  = cnt_vld ? cnt_rd : 7'd0;
  assign found    = (cum_rd > value) || (s == LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ad8_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.opcode == ad8_pkg::OP_BUILD) begin
            state_next = ad8_pkg::ST_SUM_RD;
          end else if (req.opcode == ad8_pkg::OP_BYTE && symbols_left != 7'd0) begin
            state_next = scale_pending ? ad8_pkg::ST_SCALE : ad8_pkg::ST_MUL1;
          end
        end
      end
      ad8_pkg::ST_SUM_RD:  state_next = ad8_pkg::ST_SUM_ADD;
      ad8_pkg::ST_SUM_ADD: state_next = (s == LAST_IDX) ? ad8_pkg::ST_CHECK
                                                        : ad8_pkg::ST_SUM_RD;
      ad8_pkg::ST_CHECK: begin
        if (acc == 15'd0 || acc > 15'(MAX_TOTAL)) begin
          state_next = ad8_pkg::ST_ERR;
        end else begin
          state_next = ad8_pkg::ST_BLD_RD;
        end
      end
      ad8_pkg::ST_BLD_RD:  state_next = ad8_pkg::ST_BLD_WR;
      ad8_pkg::ST_BLD_WR:  state_next = (s == LAST_IDX) ? ad8_pkg::ST_IDLE
                                                        : ad8_pkg::ST_BLD_RD;
      ad8_pkg::ST_ERR:     state_next = out_free ? ad8_pkg::ST_IDLE : ad8_pkg::ST_ERR;
      ad8_pkg::ST_SCALE: begin
        if (needs_scale) begin
          if (bits_left == 4'd0) begin
            state_next = pend_valid ? ad8_pkg::ST_FLUSH : ad8_pkg::ST_IDLE;
          end
        end else begin
          state_next = pend_valid ? ad8_pkg::ST_FLUSH : ad8_pkg::ST_MUL1;
        end
      end
      ad8_pkg::ST_MUL1:    state_next = tag_ge ? ad8_pkg::ST_DIV1 : ad8_pkg::ST_SRCH_RD;
      ad8_pkg::ST_DIV1:    state_next = div_rsp.done ? ad8_pkg::ST_SRCH_RD : ad8_pkg::ST_DIV1;
      ad8_pkg::ST_SRCH_RD: state_next = ad8_pkg::ST_SRCH_CMP;
      ad8_pkg::ST_SRCH_CMP: state_next = found ? ad8_pkg::ST_MUL2 : ad8_pkg::ST_SRCH_RD;
      ad8_pkg::ST_MUL2:    state_next = ad8_pkg::ST_DIV2;
      ad8_pkg::ST_DIV2:    state_next = div_rsp.done ? ad8_pkg::ST_MUL3 : ad8_pkg::ST_DIV2;
      ad8_pkg::ST_MUL3:    state_next = ad8_pkg::ST_DIV3;
      ad8_pkg::ST_DIV3: begin
        if (div_rsp.done) begin
          state_next = (symbols_left == 7'd1) ? ad8_pkg::ST_FLUSH : ad8_pkg::ST_SCALE;
        end
      end
      ad8_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_next = pend_last ? ad8_pkg::ST_IDLE : ad8_pkg::ST_MUL1;
        end
      end
      default: state_next = ad8_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_stall        = state != ad8_pkg::ST_IDLE;
    load_out         = (state == ad8_pkg::ST_ERR || state == ad8_pkg::ST_FLUSH) && out_free;
    div_req.start    = div_first;
    div_req.dividend = prod;
    div_req.divisor  = {2'b00, total_count};
    if (state == ad8_pkg::ST_DIV1) begin
      div_req.dividend = prod - 15'd1;
      div_req.divisor  = range9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ad8_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // count table, cleared by its valid bits
  always_ff @(posedge clk) begin
    if (accept && req.opcode == ad8_pkg::OP_LOAD && idx_ok) begin
      count_mem[req.symbol_index[AW-1:0]] <= req.symbol_count;
    end
    cnt_rd <= count_mem[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET; i++) begin
        count_valid[i] <= 1'b0;
      end
      cnt_vld <= 1'b0;
    end else begin
      if (accept && req.opcode == ad8_pkg::OP_LOAD && idx_ok) begin
        count_valid[req.symbol_index[AW-1:0]] <= 1'b1;
      end
      cnt_vld <= count_valid[s];
    end
  end

  // cumulative table, entry s holds the sum of counts 0..s
  always_ff @(posedge clk) begin
    if (state == ad8_pkg::ST_BLD_WR) begin
      cum_mem[s] <= run + cnt_val;
    end
    cum_rd <= cum_mem[s];
  end

  // control and interval state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count   <= '0;
      symbols_left  <= '0;
      interval_low  <= '0;
      interval_high <= ad8_pkg::HIGH_INIT;
      code_tag      <= '0;
      held_byte     <= '0;
      bits_left     <= '0;
      tag_loaded    <= 1'b0;
      scale_pending <= 1'b0;
      pend_valid    <= 1'b0;
      pend_last     <= 1'b0;
      div_first     <= 1'b0;
      s             <= '0;
      res_valid     <= 1'b0;
    end else begin
      div_first <= 1'b0;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ad8_pkg::ST_IDLE: begin
          if (accept && req.opcode == ad8_pkg::OP_BUILD) begin
            interval_low  <= '0;
            interval_high <= ad8_pkg::HIGH_INIT;
            code_tag      <= '0;
            held_byte     <= '0;
            bits_left     <= '0;
            tag_loaded    <= 1'b0;
            scale_pending <= 1'b0;
            s             <= '0;
          end else if (accept && req.opcode == ad8_pkg::OP_BYTE && symbols_left != 7'd0) begin
            if (!tag_loaded) begin
              code_tag   <= req.coded_byte;
              tag_loaded <= 1'b1;
            end else begin
              held_byte <= req.coded_byte;
              bits_left <= ad8_pkg::BYTE_BITS;
            end
          end
        end
        ad8_pkg::ST_SUM_ADD: begin
          if (s != LAST_IDX) begin
            s <= s + AW'(1);
          end
        end
        ad8_pkg::ST_CHECK: begin
          s <= '0;
          if (acc == 15'd0 || acc > 15'(MAX_TOTAL)) begin
            total_count  <= '0;
            symbols_left <= '0;
          end
        end
        ad8_pkg::ST_BLD_WR: begin
          if (s == LAST_IDX) begin
            total_count  <= acc[6:0];
            symbols_left <= acc[6:0];
          end else begin
            s <= s + AW'(1);
          end
        end
        ad8_pkg::ST_SCALE: begin
          if (needs_scale) begin
            if (bits_left == 4'd0) begin
              pend_last <= 1'b1;
            end else begin
              interval_low  <= {interval_low[6:0], 1'b0} ^ {~same_top, 7'd0};
              interval_high <= {interval_high[6:0], 1'b1} ^ {~same_top, 7'd0};
              code_tag      <= {code_tag[6:0], in_bit} ^ {~same_top, 7'd0};
              bits_left     <= bits_left - 4'd1;
            end
          end else begin
            scale_pending <= 1'b0;
            pend_last     <= 1'b0;
          end
        end
        ad8_pkg::ST_MUL1: begin
          s <= '0;
          div_first <= tag_ge;
        end
        ad8_pkg::ST_SRCH_CMP: begin
          if (!found) begin
            s <= s + AW'(1);
          end
        end
        ad8_pkg::ST_MUL2: div_first <= 1'b1;
        ad8_pkg::ST_MUL3: div_first <= 1'b1;
        ad8_pkg::ST_DIV3: begin
          if (div_rsp.done) begin
            interval_low  <= interval_low + lo_off;
            interval_high <= interval_low + div_rsp.quotient[7:0] - 8'd1;
            symbols_left  <= symbols_left - 7'd1;
            scale_pending <= symbols_left != 7'd1;
            pend_valid    <= 1'b1;
            pend_last     <= symbols_left == 7'd1;
          end
        end
        ad8_pkg::ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ad8_pkg::ST_IDLE: begin
        acc <= '0;
      end
      ad8_pkg::ST_SUM_ADD: acc <= acc + 15'(cnt_val);
      ad8_pkg::ST_CHECK:   run <= '0;
      ad8_pkg::ST_BLD_WR:  run <= run + cnt_val;
      ad8_pkg::ST_MUL1: begin
        prod  <= 15'(first9 * total_count);
        value <= '0;
        prev  <= '0;
      end
      ad8_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= {8'd0, total_count}) begin
            value <= total_count - 7'd1;
          end else begin
            value <= div_rsp.quotient[6:0];
          end
        end
      end
      ad8_pkg::ST_SRCH_CMP: begin
        if (found) begin
          k      <= s;
          cum_hi <= cum_rd;
          cum_lo <= prev;
        end else begin
          prev <= cum_rd;
        end
      end
      ad8_pkg::ST_MUL2: prod <= 15'(range9 * cum_lo);
      ad8_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          lo_off <= div_rsp.quotient[7:0];
        end
      end
      ad8_pkg::ST_MUL3: prod <= 15'(range9 * cum_hi);
      ad8_pkg::ST_DIV3: begin
        if (div_rsp.done) begin
          pend_sym <= 8'(k);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == ad8_pkg::ST_ERR) begin
        res.decoded_symbol <= '0;
        res.last           <= 1'b1;
        res.error          <= 1'b1;
      end else begin
        res.decoded_symbol <= pend_sym;
        res.last           <= pend_last;
        res.error          <= 1'b0;
      end
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error |-> res.last)
    else $error("error result without last flag");

  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    state == ad8_pkg::ST_FLUSH |-> pend_valid)
    else $error("flush with no pending symbol");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ad8_pkg::ST_DIV1 || state == ad8_pkg::ST_DIV2 ||
                      state == ad8_pkg::ST_DIV3))
    else $error("divider finished outside a divide step");

  a_left_le_total: assert property (@(posedge clk) disable iff (rst)
    symbols_left <= total_count)
    else $error("more symbols left than the total");

endmodule

FILE: verif/tb_top.sv
// testbench for the 8-bit arithmetic decoder: random count tables and coded streams
class decode_scoreboard;
  logic [6:0] counts[256];
  logic [6:0] cum[257];
  logic [6:0] total;
  logic [7:0] lo, hi, tag, held;
  logic [3:0] bits_left;
  logic       tag_loaded, scale_pending;
  logic [6:0] symbols_left;
  ad8_pkg::res_t expected_q[$];
  int fails;

  function new();
    foreach (counts[i]) counts[i] = '0;
    foreach (cum[i]) cum[i] = '0;
    total = '0; lo = '0; hi = ad8_pkg::HIGH_INIT; tag = '0; held = '0;
    bits_left = '0; tag_loaded = 0; scale_pending = 0; symbols_left = '0;
    fails = 0;
  endfunction

  function bit must_scale();
    return (lo[7] == hi[7]) || (lo[7:6] == 2'b01 && hi[7:6] == 2'b10);
  endfunction

  function void shift_in();
    bit same;
    bit b;
    same = (lo[7] == hi[7]);
    b = held[(4'd8 - bits_left) & 4'd7];
    bits_left = bits_left - 4'd1;
    lo = {lo[6:0], 1'b0};
    hi = {hi[6:0], 1'b1};
    tag = {tag[6:0], b};
    if (!same) begin
      lo ^= 8'h80; hi ^= 8'h80; tag ^= 8'h80;
    end
  endfunction

  function logic [7:0] next_symbol();
    int range, value, k, base;
    range = int'(8'(hi - lo)) + 1;
    value = 0;
    k = 255;
    if (tag >= lo) value = ((int'(tag) - int'(lo) + 1) * total - 1) / range;
    if (value >= total) value = total - 1;
    for (int s = 0; s < 256; s++) begin
      if (cum[s+1] > value) begin
        k = s;
        break;
      end
    end
    base = lo;
    lo = 8'(base + (range * cum[k]) / total);
    hi = 8'(base + (range * cum[k+1]) / total - 1);
    return k[7:0];
  endfunction

  function void note_request(ad8_pkg::req_t r);
    int acc, n;
    ad8_pkg::res_t e;
    case (ad8_pkg::opcode_t'(r.opcode))
      ad8_pkg::OP_LOAD: counts[r.symbol_index] = r.symbol_count;
      ad8_pkg::OP_BUILD: begin
        acc = 0;
        foreach (counts[i]) acc += counts[i];
        lo = '0; hi = ad8_pkg::HIGH_INIT; tag = '0; held = '0; bits_left = '0;
        tag_loaded = 0; scale_pending = 0;
        if (acc == 0 || acc > 64) begin
          total = '0; symbols_left = '0;
          e = '{decoded_symbol: 8'd0, last: 1'b1, error: 1'b1};
          expected_q = {expected_q, e};
        end else begin
          cum[0] = '0;
          for (int s = 0; s < 256; s++) cum[s+1] = cum[s] + counts[s];
          total = 7'(acc); symbols_left = 7'(acc);
        end
      end
      ad8_pkg::OP_BYTE: begin
        if (symbols_left == 0) return;
        if (!tag_loaded) begin
          tag = r.coded_byte; tag_loaded = 1;
        end else begin
          held = r.coded_byte; bits_left = ad8_pkg::BYTE_BITS;
        end
        n = 0;
        while (symbols_left > 0 && total > 0 && n < 64) begin
          if (scale_pending) begin
            while (must_scale() && bits_left != 0) shift_in();
            if (must_scale()) break;
            scale_pending = 0;
          end
          e = '{decoded_symbol: next_symbol(), last: 1'b0, error: 1'b0};
          expected_q = {expected_q, e};
          n++;
          symbols_left--;
          scale_pending = symbols_left > 0;
        end
        if (n > 0) expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function void check_result(ad8_pkg::res_t got);
    ad8_pkg::res_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result sym=%0d last=%0b err=%0b", $time,
               got.decoded_symbol, got.last, got.error);
      fails++;
      return;
    end
    e = expected_q.pop_front();
    if (got.decoded_symbol !== e.decoded_symbol) begin
      $display("%0t: decoded_symbol expected %0d actual %0d", $time,
               e.decoded_symbol, got.decoded_symbol);
      fails++;
    end
    if (got.last !== e.last) begin
      $display("%0t: last expected %0b actual %0b", $time, e.last, got.last);
      fails++;
    end
    if (got.error !== e.error) begin
      $display("%0t: error expected %0b actual %0b", $time, e.error, got.error);
      fails++;
    end
  endfunction
endclass

module tb_top;

  logic clk, rst;
  logic req_valid, req_stall, res_valid, res_stall;
  ad8_pkg::req_t req;
  ad8_pkg::res_t res;
  decode_scoreboard sb;
  int sent;
  bit steady;

  arithmetic_decoder_8bit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 100000000);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: check and random stall
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(res);
      res_stall <= steady ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  task automatic send(ad8_pkg::opcode_t op, logic [7:0] idx, logic [6:0] cnt,
                      logic [7:0] b);
    ad8_pkg::req_t r;
    r = '{opcode: op, symbol_index: idx, symbol_count: cnt, coded_byte: b};
    while (!steady && $urandom_range(99) < 35) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    sent++;
  endtask

  // zero every count so a new table starts clean
  task automatic clear_counts();
    for (int i = 0; i < 256; i++)
      if (sb.counts[i] != 0) send(ad8_pkg::OP_LOAD, i[7:0], 7'd0, 8'($urandom()));
  endtask

  task automatic feed_bytes(int max_bytes);
    for (int i = 0; i < max_bytes && sb.symbols_left != 0; i++)
      send(ad8_pkg::OP_BYTE, 8'($urandom()), 7'($urandom()), 8'($urandom()));
  endtask

  // one well-formed decode: table, build, coded stream
  task automatic decode_run();
    int nsym, left;
    logic [7:0] idx;
    logic [6:0] c;
    clear_counts();
    nsym = $urandom_range(1, 5);
    left = ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 16);
    for (int i = 0; i < nsym && left > 0; i++) begin
      idx = ($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
                                     : 8'($urandom_range(0, 15));
      c = (i == nsym - 1) ? 7'(left) : 7'($urandom_range(1, left));
      if (c > left) c = 7'(left);
      send(ad8_pkg::OP_LOAD, idx, c, 8'($urandom()));
      left -= c;
    end
    if (sb.counts.sum() with (int'(item)) == 0)
      send(ad8_pkg::OP_LOAD, 8'd1, 7'd2, 8'($urandom()));
    send(ad8_pkg::OP_BUILD, 8'($urandom()), 7'($urandom()), 8'($urandom()));
    feed_bytes(($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : 200);
  endtask

  initial begin
    logic [6:0] rc;
    sb = new();
    sent = 0;
    steady = 0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    res_stall <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, unused opcode, byte while idle
    send(ad8_pkg::OP_BUILD, 8'hFF, 7'h7F, 8'hFF);
    send(ad8_pkg::OP_NONE, 8'hFF, 7'h40, 8'hFF);
    send(ad8_pkg::OP_BYTE, 8'h00, 7'h00, 8'hA5);
    // single symbol at the top of the alphabet with the largest total
    send(ad8_pkg::OP_LOAD, 8'd255, 7'd64, 8'h00);
    send(ad8_pkg::OP_BUILD, 8'h00, 7'h00, 8'h00);
    send(ad8_pkg::OP_BYTE, 8'h00, 7'h3F, 8'h00);
    send(ad8_pkg::OP_BYTE, 8'hFF, 7'h00, 8'hFF);
    feed_bytes(12);
    // total just over the limit
    send(ad8_pkg::OP_LOAD, 8'd0, 7'd1, 8'h00);
    send(ad8_pkg::OP_BUILD, 8'h00, 7'h00, 8'h00);
    // two symbols, tag at the top, counts changed mid decode
    send(ad8_pkg::OP_LOAD, 8'd255, 7'd1, 8'h00);
    send(ad8_pkg::OP_BUILD, 8'h00, 7'h00, 8'h00);
    send(ad8_pkg::OP_BYTE, 8'h00, 7'h00, 8'hFF);
    send(ad8_pkg::OP_LOAD, 8'd0, 7'd63, 8'h00);
    send(ad8_pkg::OP_BYTE, 8'h00, 7'h00, 8'h00);
    feed_bytes(4);
    send(ad8_pkg::OP_NONE, 8'h00, 7'h00, 8'h00);

    while (sent < 410) begin
      if (sent > 180 && sent < 260) steady = 1;
      else steady = 0;
      case ($urandom_range(9))
        0: send(ad8_pkg::OP_NONE, 8'($urandom()), 7'($urandom()), 8'($urandom()));
        1: begin
          // bad total: overflow or random junk
          rc = 7'($urandom_range(33, 64));
          send(ad8_pkg::OP_LOAD, 8'($urandom()), rc, 8'($urandom()));
          send(ad8_pkg::OP_LOAD, 8'($urandom()), 7'd64, 8'($urandom()));
          send(ad8_pkg::OP_BUILD, 8'($urandom()), 7'($urandom()), 8'($urandom()));
          send(ad8_pkg::OP_BYTE, 8'($urandom()), 7'($urandom()), 8'($urandom()));
        end
        default: decode_run();
      endcase
    end
    req_valid <= 1'b0;
    steady = 0;

    for (int i = 0; i < 2000000 && sb.expected_q.size() != 0; i++) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
design/ad8_pkg.sv
design/ad8_div.sv
design/arithmetic_decoder_8bit.sv
verif/tb_top.sv
